FILE: design/dke_pkg.sv
package dke_pkg;

	// kernel selection codes
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_QUARTIC    = 3'd0;
	localparam kind_t KIND_NORMAL     = 3'd1;
	localparam kind_t KIND_UNIFORM    = 3'd2;
	localparam kind_t KIND_TRIANGULAR = 3'd3;
	localparam kind_t KIND_NEG_EXP    = 3'd4;

	// configuration register indexes
	localparam logic REG_KERNEL_KIND = 1'b0;
	localparam logic REG_BANDWIDTH   = 1'b1;

	// Q0.32 constants, 1.0 needs the extra bit
	localparam logic [32:0] ONE_Q32           = 33'h1_0000_0000;
	localparam logic [31:0] THREE_OVER_PI_Q32 = 32'd4101391653;
	localparam logic [31:0] INV_TWO_PI_Q32    = 32'd683565276;
	localparam logic [31:0] EXP_M1_Q32        = 32'd1580030169;

	// exp(-x): series length and integer part at and beyond which the value is zero
	localparam int          SERIES_TERMS = 12;
	localparam int          EXP_LIMIT    = 23;
	localparam logic [4:0]  EXP_N_MAX    = 5'd23;

endpackage

FILE: design/dke_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Requires in_num >> QW to be below in_den.
module dke_div #(
	parameter int DW = 32,
	parameter int QW = 35,
	parameter int TW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DW+QW-1:0]  in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [TW-1:0]     in_tag,
	output logic              out_valid,
	output logic [QW-1:0]     out_quo,
	output logic [TW-1:0]     out_tag
);

	logic          vld_s [1:QW];
	logic [DW-1:0] rem_s [1:QW];
	logic [QW-1:0] low_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [TW-1:0] tag_s [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic          pv;
		logic [DW-1:0] prem;
		logic [DW-1:0] pden;
		logic [QW-1:0] plow;
		logic [QW-1:0] pquo;
		logic [TW-1:0] ptag;
		logic [DW:0]   cand;
		logic          ge;

		if (i == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = in_num[DW+QW-1:QW];
			assign plow = in_num[QW-1:0];
			assign pquo = '0;
			assign pden = in_den;
			assign ptag = in_tag;
		end else begin : g_next
			assign pv   = vld_s[i];
			assign prem = rem_s[i];
			assign plow = low_s[i];
			assign pquo = quo_s[i];
			assign pden = den_s[i];
			assign ptag = tag_s[i];
		end

		// shift in next numerator bit, subtract when it fits
		assign cand = {prem, plow[QW-1]};
		assign ge   = cand >= {1'b0, pden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? DW'(cand - {1'b0, pden}) : cand[DW-1:0];
			low_s[i+1] <= plow << 1;
			quo_s[i+1] <= {pquo[QW-2:0], ge};
			den_s[i+1] <= pden;
			tag_s[i+1] <= ptag;
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

FILE: design/dke_mulq.sv
// a * g / 2^32 with g in [0, 1.0] Q0.32; two stages
module dke_mulq #(
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [62:0]   in_a,
	input  logic [32:0]   in_g,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [62:0]   out_res,
	output logic [TW-1:0] out_tag
);

	logic          vld_s1, vld_s2;
	logic [62:0]   hi_s1;
	logic [63:0]   lo_s1;
	logic          byp_s1;
	logic [62:0]   a_s1;
	logic [TW-1:0] tag_s1, tag_s2;
	logic [62:0]   res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// partial products of the upper and lower halves
	always_ff @(posedge clk) begin
		hi_s1  <= 63'(in_a[62:32]) * 63'(in_g[31:0]);
		lo_s1  <= 64'(in_a[31:0]) * 64'(in_g[31:0]);
		byp_s1 <= in_g[32];
		a_s1   <= in_a;
		tag_s1 <= in_tag;
	end

	// g of 1.0 passes a through
	always_ff @(posedge clk) begin
		res_s2 <= byp_s1 ? a_s1 : 63'(hi_s1 + 63'(lo_s1[63:32]));
		tag_s2 <= tag_s1;
	end

	assign out_valid = vld_s2;
	assign out_res   = res_s2;
	assign out_tag   = tag_s2;

endmodule

FILE: design/dke_exp.sv
// exp(-(n + f)) in Q0.32: alternating series for the fraction, one term per
// three stages, then one stage per multiplication by exp(-1).
module dke_exp #(
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [31:0]   in_f,
	input  logic [4:0]    in_n,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [32:0]   out_g,
	output logic [TW-1:0] out_tag
);

	localparam int NT = dke_pkg::SERIES_TERMS;
	localparam int NM = dke_pkg::EXP_LIMIT - 1;

	logic          vld_ser  [1:NT];
	logic [31:0]   term_ser [1:NT];
	logic [32:0]   sum_ser  [1:NT];
	logic [31:0]   f_ser    [1:NT];
	logic [4:0]    n_ser    [1:NT];
	logic [TW-1:0] tag_ser  [1:NT];

	logic          vld_m [1:NM];
	logic [32:0]   sum_m [1:NM];
	logic [4:0]    n_m   [1:NM];
	logic [TW-1:0] tag_m [1:NM];

	// first term is f itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ser[1] <= 1'b0;
		end else begin
			vld_ser[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		term_ser[1] <= in_f;
		sum_ser[1]  <= dke_pkg::ONE_Q32 - 33'(in_f);
		f_ser[1]    <= in_f;
		n_ser[1]    <= in_n;
		tag_ser[1]  <= in_tag;
	end

	for (genvar k = 2; k <= NT; k++) begin : g_term
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / k);
		localparam logic [3:0]  KV    = 4'(k);
		localparam bit          ODD   = (k % 2) == 1;

		logic          va_s, vb_s;
		logic [63:0]   prod_s;
		logic [32:0]   suma_s, sumb_s;
		logic [31:0]   fa_s, fb_s;
		logic [4:0]    na_s, nb_s;
		logic [TW-1:0] taga_s, tagb_s;
		logic [31:0]   val_s, est_s;
		logic [35:0]   back;
		logic [35:0]   rem;
		logic [31:0]   quo;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s       <= 1'b0;
				vb_s       <= 1'b0;
				vld_ser[k] <= 1'b0;
			end else begin
				va_s       <= vld_ser[k-1];
				vb_s       <= va_s;
				vld_ser[k] <= vb_s;
			end
		end

		// term * f
		always_ff @(posedge clk) begin
			prod_s <= 64'(term_ser[k-1]) * 64'(f_ser[k-1]);
			suma_s <= sum_ser[k-1];
			fa_s   <= f_ser[k-1];
			na_s   <= n_ser[k-1];
			taga_s <= tag_ser[k-1];
		end

		// estimate of the quotient by k, low by at most one
		always_ff @(posedge clk) begin
			val_s  <= prod_s[63:32];
			est_s  <= 32'((64'(prod_s[63:32]) * 64'(RECIP)) >> 32);
			sumb_s <= suma_s;
			fb_s   <= fa_s;
			nb_s   <= na_s;
			tagb_s <= taga_s;
		end

		always_comb begin
			back = 36'(est_s) * 36'(KV);
			rem  = 36'(val_s) - back;
			quo  = (rem >= 36'(KV)) ? est_s + 32'd1 : est_s;
		end

		always_ff @(posedge clk) begin
			term_ser[k] <= quo;
			if (ODD) begin
				sum_ser[k] <= sumb_s - 33'(quo);
			end else begin
				sum_ser[k] <= sumb_s + 33'(quo);
			end
			f_ser[k]   <= fb_s;
			n_ser[k]   <= nb_s;
			tag_ser[k] <= tagb_s;
		end
	end

	// stage j multiplies by exp(-1) when j <= n; a sum of 1.0 is multiplied too
	for (genvar j = 1; j <= NM; j++) begin : g_mul
		logic          pv;
		logic [32:0]   psum;
		logic [4:0]    pn;
		logic [TW-1:0] ptag;
		logic [64:0]   prod;
		logic          apply;

		if (j == 1) begin : g_first
			assign pv   = vld_ser[NT];
			assign psum = sum_ser[NT];
			assign pn   = n_ser[NT];
			assign ptag = tag_ser[NT];
		end else begin : g_next
			assign pv   = vld_m[j-1];
			assign psum = sum_m[j-1];
			assign pn   = n_m[j-1];
			assign ptag = tag_m[j-1];
		end

		assign prod  = 65'(psum) * 65'(dke_pkg::EXP_M1_Q32);
		assign apply = 5'(j) <= pn;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m[j] <= 1'b0;
			end else begin
				vld_m[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			sum_m[j] <= apply ? prod[64:32] : psum;
			n_m[j]   <= pn;
			tag_m[j] <= ptag;
		end
	end

	assign out_valid = vld_m[NM];
	assign out_g     = (n_m[NM] >= dke_pkg::EXP_N_MAX) ? '0 : sum_m[NM];
	assign out_tag   = tag_m[NM];

endmodule

FILE: design/density_kernel_evaluator.sv
// Kernel density contribution, one word per cycle.
// Pipeline: 134 register stages, among them the ratio divider (35 stages),
// the exp unit (56) and the bandwidth^2 divider (33).
// Throughput: one word every cycle; busy stays low and the receiver cannot stall.
// Reset: arst_n clears all valid bits; kernel kind goes to quartic, bandwidth to 1.0.
module density_kernel_evaluator #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        distance,
	input  logic signed [31:0] intensity,
	input  logic signed [31:0] weight,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic signed [31:0] contribution,
	output logic               saturated
);

	typedef struct packed {
		dke_pkg::kind_t kind;
		logic [31:0]    t;
		logic [31:0]    d;
		logic           neg;
		logic [62:0]    p;
	} item_t;

	typedef struct packed {
		item_t       it;
		logic [32:0] g1;
		logic [32:0] gtri;
		logic        in_bw;
		logic        near;
	} shape_t;

	typedef struct packed {
		dke_pkg::kind_t kind;
		logic           neg;
		logic           in_bw;
		logic [63:0]    tsq;
	} post_t;

	typedef struct packed {
		post_t       pst;
		logic [32:0] g;
	} gpost_t;

	typedef struct packed {
		dke_pkg::kind_t kind;
		logic           neg;
		logic           in_bw;
		logic           ovf;
		logic [62:0]    simple;
	} fin_t;

	// configuration
	dke_pkg::kind_t kind_q;
	logic [31:0]    bw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= dke_pkg::KIND_QUARTIC;
			bw_q   <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				dke_pkg::REG_KERNEL_KIND: kind_q <= cfg_wdata[2:0];
				dke_pkg::REG_BANDWIDTH:   bw_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: take the word, magnitudes and sign
	logic           vld_s1;
	dke_pkg::kind_t kind_s1;
	logic [31:0]    t_s1, d_s1, mi_s1, mw_s1;
	logic           neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_q;
		t_s1    <= (bw_q == '0) ? 32'd1 : bw_q;
		d_s1    <= distance;
		neg_s1  <= intensity[31] ^ weight[31];
		mi_s1   <= intensity[31] ? ~$unsigned(intensity) + 32'd1 : $unsigned(intensity);
		mw_s1   <= weight[31] ? ~$unsigned(weight) + 32'd1 : $unsigned(weight);
	end

	// stage 2: |I*W|
	logic  vld_s2;
	item_t it_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s2.kind <= kind_s1;
		it_s2.t    <= t_s1;
		it_s2.d    <= d_s1;
		it_s2.neg  <= neg_s1;
		it_s2.p    <= 63'(64'(mi_s1) * 64'(mw_s1));
	end

	// ratio s = d * 2^32 / t, valid while d < 8t
	logic        q_v;
	logic [34:0] q_quo;
	item_t       q_it;

	dke_div #(
		.DW (32),
		.QW (35),
		.TW ($bits(item_t))
	) u_ratio_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_num    ({3'b000, it_s2.d, 32'd0}),
		.in_den    (it_s2.t),
		.in_tag    (it_s2),
		.out_valid (q_v),
		.out_quo   (q_quo),
		.out_tag   (q_it)
	);

	// stage 3: square of s (quartic) or of s in Q.16 (normal)
	logic        vld_s3;
	item_t       it_s3;
	logic [34:0] q_s3;
	logic [63:0] sq_s3;
	logic        inside_s3, near_s3;
	logic [31:0] sq_op;

	assign sq_op = (q_it.kind == dke_pkg::KIND_NORMAL) ? 32'(q_quo[34:16]) : q_quo[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= q_v;
		end
	end

	always_ff @(posedge clk) begin
		it_s3     <= q_it;
		q_s3      <= q_quo;
		sq_s3     <= 64'(sq_op) * 64'(sq_op);
		inside_s3 <= q_it.d <= q_it.t;
		near_s3   <= 35'(q_it.d) < {q_it.t, 3'b000};
	end

	// exp argument and the polynomial shapes
	logic [63:0] dx, xexp, xarg;
	logic [4:0]  n_c;
	shape_t      sh_c;

	always_comb begin
		dx   = 64'(it_s3.d) << (32 - FRAC_BITS);
		xexp = dx + (dx << 1);
		xarg = (it_s3.kind == dke_pkg::KIND_NEG_EXP) ? xexp : {1'b0, sq_s3[63:1]};
		n_c  = (xarg[63:32] >= 32'(dke_pkg::EXP_LIMIT)) ? dke_pkg::EXP_N_MAX : xarg[36:32];
		sh_c.it     = it_s3;
		sh_c.g1     = (q_s3[32:0] >= dke_pkg::ONE_Q32) ? '0
			: dke_pkg::ONE_Q32 - {1'b0, sq_s3[63:32]};
		sh_c.gtri   = dke_pkg::ONE_Q32 - q_s3[32:0];
		sh_c.in_bw  = inside_s3;
		sh_c.near   = near_s3;
	end

	logic        e_v;
	logic [32:0] e_g;
	shape_t      e_sh;

	dke_exp #(
		.TW ($bits(shape_t))
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_f      (xarg[31:0]),
		.in_n      (n_c),
		.in_tag    (sh_c),
		.out_valid (e_v),
		.out_g     (e_g),
		.out_tag   (e_sh)
	);

	// stage 5: shape g, scale constant, tau^2
	logic        vld_s5;
	logic [62:0] p_s5;
	logic [32:0] c_s5;
	gpost_t      gp_s5;
	logic [32:0] gq;
	logic [32:0] g_c;
	logic [32:0] c_c;

	assign gq = e_sh.g1[32] ? dke_pkg::ONE_Q32
		: 33'((64'(e_sh.g1[31:0]) * 64'(e_sh.g1[31:0])) >> 32);

	always_comb begin
		case (e_sh.it.kind)
			dke_pkg::KIND_QUARTIC: begin
				g_c = gq;
				c_c = {1'b0, dke_pkg::THREE_OVER_PI_Q32};
			end
			dke_pkg::KIND_NORMAL: begin
				g_c = e_sh.near ? e_g : '0;
				c_c = {1'b0, dke_pkg::INV_TWO_PI_Q32};
			end
			dke_pkg::KIND_UNIFORM: begin
				g_c = dke_pkg::ONE_Q32;
				c_c = dke_pkg::ONE_Q32;
			end
			dke_pkg::KIND_TRIANGULAR: begin
				g_c = e_sh.gtri;
				c_c = dke_pkg::ONE_Q32;
			end
			dke_pkg::KIND_NEG_EXP: begin
				g_c = e_g;
				c_c = dke_pkg::ONE_Q32;
			end
			default: begin
				g_c = '0;
				c_c = dke_pkg::ONE_Q32;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= e_v;
		end
	end

	always_ff @(posedge clk) begin
		p_s5              <= e_sh.it.p;
		c_s5              <= c_c;
		gp_s5.g           <= g_c;
		gp_s5.pst.kind    <= e_sh.it.kind;
		gp_s5.pst.neg     <= e_sh.it.neg;
		gp_s5.pst.in_bw   <= e_sh.in_bw;
		gp_s5.pst.tsq     <= 64'(e_sh.it.t) * 64'(e_sh.it.t);
	end

	// p * constant, then * g
	logic        m1_v;
	logic [62:0] m1_res;
	gpost_t      m1_gp;

	dke_mulq #(
		.TW ($bits(gpost_t))
	) u_mul_const (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_a      (p_s5),
		.in_g      (c_s5),
		.in_tag    (gp_s5),
		.out_valid (m1_v),
		.out_res   (m1_res),
		.out_tag   (m1_gp)
	);

	logic        m2_v;
	logic [62:0] m2_res;
	post_t       m2_pst;

	dke_mulq #(
		.TW ($bits(post_t))
	) u_mul_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m1_v),
		.in_a      (m1_res),
		.in_g      (m1_gp.g),
		.in_tag    (m1_gp.pst),
		.out_valid (m2_v),
		.out_res   (m2_res),
		.out_tag   (m2_pst)
	);

	// stage 6: mag * 2^F / tau^2 set-up, overflow means clipping anyway
	logic        vld_s6;
	logic [96:0] num_s6;
	logic [63:0] den_s6;
	fin_t        fin_s6;
	logic [96:0] num_c;

	assign num_c = 97'(m2_res) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= m2_v;
		end
	end

	always_ff @(posedge clk) begin
		num_s6        <= num_c;
		den_s6        <= m2_pst.tsq;
		fin_s6.kind   <= m2_pst.kind;
		fin_s6.neg    <= m2_pst.neg;
		fin_s6.in_bw  <= m2_pst.in_bw;
		fin_s6.ovf    <= num_c[96:33] >= m2_pst.tsq;
		fin_s6.simple <= m2_res >> FRAC_BITS;
	end

	logic        d2_v;
	logic [32:0] d2_quo;
	fin_t        d2_fin;

	dke_div #(
		.DW (64),
		.QW (33),
		.TW ($bits(fin_t))
	) u_area_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_num    (num_s6),
		.in_den    (den_s6),
		.in_tag    (fin_s6),
		.out_valid (d2_v),
		.out_quo   (d2_quo),
		.out_tag   (d2_fin)
	);

	// select, clip, apply sign
	logic [63:0] mag, limit, clipped;
	logic        sat_c;
	logic [31:0] val_c;

	always_comb begin
		case (d2_fin.kind)
			dke_pkg::KIND_QUARTIC:
				mag = !d2_fin.in_bw ? '0 : (d2_fin.ovf ? '1 : 64'(d2_quo));
			dke_pkg::KIND_NORMAL:
				mag = d2_fin.ovf ? '1 : 64'(d2_quo);
			dke_pkg::KIND_UNIFORM,
			dke_pkg::KIND_TRIANGULAR,
			dke_pkg::KIND_NEG_EXP:
				mag = d2_fin.in_bw ? 64'(d2_fin.simple) : '0;
			default:
				mag = '0;
		endcase
		limit   = d2_fin.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		sat_c   = mag > limit;
		clipped = sat_c ? limit : mag;
		val_c   = d2_fin.neg ? ~clipped[31:0] + 32'd1 : clipped[31:0];
	end

	logic        done_q;
	logic [31:0] contribution_q;
	logic        saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		contribution_q <= val_c;
		saturated_q    <= sat_c;
	end

	assign done         = done_q;
	assign contribution = $signed(contribution_q);
	assign saturated    = saturated_q;

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int             LATENCY_WAIT  = 140;
	localparam dke_pkg::kind_t KIND_SPARE_LO = 3'd5;
	localparam dke_pkg::kind_t KIND_SPARE_HI = 3'd7;
	localparam logic [63:0] WORD_ONE = 64'h1_0000_0000;
	localparam logic [63:0] LOW_MASK = 64'hFFFF_FFFF;
	localparam logic [31:0] Q_ONE    = 32'h0001_0000;

	typedef struct packed {
		logic [31:0] contribution;
		logic        saturated;
	} density_word_t;

	typedef struct {
		dke_pkg::kind_t kind;
		logic [31:0]    bw;
		logic [31:0]    dst;
		logic [31:0]    inten;
		logic [31:0]    wt;
		bit             typed;
		logic [31:0]    contribution;
		logic           saturated;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [31:0]        distance;
	logic signed [31:0] intensity;
	logic signed [31:0] weight;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_wdata;
	logic               done;
	logic signed [31:0] contribution;
	logic               saturated;

	// model copy of the two registers
	dke_pkg::kind_t cur_kind;
	logic [31:0]    cur_bw;

	density_word_t pending_words[$];
	int unsigned   mismatches;
	stim_row_t     directed[$];

	density_kernel_evaluator u_top (.*);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// generous overall limit
	initial begin
		#3ms;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// a * g / 2^32, g in [0, 2^32]
	function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] g);
		logic [63:0] hi;
		logic [63:0] lo;
		if (g >= WORD_ONE) begin
			return a;
		end
		hi = (a >> 32) * g;
		lo = (a & LOW_MASK) * g;
		return hi + (lo >> 32);
	endfunction

	// q * 2^16 / t, all ones when too wide
	function automatic logic [63:0] scaled_quot(input logic [63:0] q, input logic [63:0] t);
		logic [63:0] a;
		logic [63:0] r;
		a = q / t;
		r = q % t;
		if (a >= (64'd1 << 47)) begin
			return '1;
		end
		return (a << 16) + ((r << 16) / t);
	endfunction

	// exp(-x), x in Q.32, result in Q0.32
	function automatic logic [63:0] decay(input logic [63:0] x);
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] sum;
		logic [63:0] term;
		n = x >> 32;
		f = x & LOW_MASK;
		sum = WORD_ONE;
		term = WORD_ONE;
		if (n >= dke_pkg::EXP_LIMIT) begin
			return 64'd0;
		end
		for (int k = 1; k <= dke_pkg::SERIES_TERMS; k++) begin
			term = ((term * f) >> 32) / k;
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int k = 0; k < n; k++) begin
			sum = frac_mul(sum, {32'd0, dke_pkg::EXP_M1_Q32});
		end
		return sum;
	endfunction

	function automatic logic [63:0] abs_word(input logic [31:0] raw);
		return raw[31] ? (WORD_ONE - {32'd0, raw}) : {32'd0, raw};
	endfunction

	function automatic density_word_t kernel_contribution(input logic [31:0] dst,
			input logic [31:0] inten, input logic [31:0] wt);
		density_word_t res;
		logic [63:0] d;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] mag;
		logic [63:0] s;
		logic [63:0] g;
		logic [63:0] limit;
		logic        neg;
		d = {32'd0, dst};
		t = (cur_bw == 0) ? 64'd1 : {32'd0, cur_bw};
		neg = inten[31] ^ wt[31];
		p = abs_word(inten) * abs_word(wt);
		mag = 64'd0;
		case (cur_kind)
			dke_pkg::KIND_QUARTIC: begin
				if (d <= t) begin
					s = (d << 32) / t;
					if (s >= WORD_ONE) begin
						g = 64'd0;
					end else begin
						g = WORD_ONE - ((s * s) >> 32);
						g = frac_mul(g, g);
					end
					mag = frac_mul(frac_mul(p, {32'd0, dke_pkg::THREE_OVER_PI_Q32}), g);
					mag = scaled_quot(mag, t) / t;
				end
			end
			dke_pkg::KIND_NORMAL: begin
				if (d >= 8 * t) begin
					g = 64'd0;
				end else begin
					s = ((d << 32) / t) >> 16;
					g = decay((s * s) >> 1);
				end
				mag = frac_mul(frac_mul(p, {32'd0, dke_pkg::INV_TWO_PI_Q32}), g);
				mag = scaled_quot(mag, t) / t;
			end
			dke_pkg::KIND_UNIFORM: begin
				if (d <= t) mag = p >> 16;
			end
			dke_pkg::KIND_TRIANGULAR: begin
				if (d <= t) begin
					s = (d << 32) / t;
					mag = frac_mul(p, WORD_ONE - s) >> 16;
				end
			end
			dke_pkg::KIND_NEG_EXP: begin
				if (d <= t) mag = frac_mul(p, decay((d << 16) * 3)) >> 16;
			end
			default: mag = 64'd0;
		endcase
		limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		res.saturated = 1'b0;
		if (mag > limit) begin
			mag = limit;
			res.saturated = 1'b1;
		end
		res.contribution = (neg && mag != 0) ? 32'(WORD_ONE - mag) : mag[31:0];
		return res;
	endfunction

	// result checker, sampled at the edge that ends the strobe cycle
	always @(posedge clk) begin
		density_word_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				report("result word with none expected");
			end else begin
				want = pending_words.pop_front();
				if (contribution !== want.contribution)
					report($sformatf("contribution %h, expected %h", contribution,
						want.contribution));
				if (saturated !== want.saturated)
					report($sformatf("saturated %b, expected %b", saturated, want.saturated));
			end
		end
	end

	// drop start and let the pipeline drain before touching registers
	task automatic settle();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == dke_pkg::REG_KERNEL_KIND) cur_kind = dke_pkg::kind_t'(value[2:0]);
		else cur_bw = value;
	endtask

	// present one word right after an edge, predicted or with a typed expectation
	task automatic send_word(input logic [31:0] dst, input logic [31:0] inten,
			input logic [31:0] wt, input int gap, input bit typed,
			input density_word_t typed_res);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		distance  <= dst;
		intensity <= inten;
		weight    <= wt;
		do @(posedge clk); while (busy);
		if (typed) pending_words.push_back(typed_res);
		else pending_words.push_back(kernel_contribution(dst, inten, wt));
	endtask

	function automatic logic [31:0] pick_distance(input logic [31:0] bw);
		logic [31:0] t;
		t = (bw == 0) ? 32'd1 : bw;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return t;
			2: return t + 32'd1;
			3: return 32'd0;
			4: return (t > 32'h1FFF_FFFF) ? $urandom : $urandom_range(0, 8 * t);
			default: return $urandom_range(0, t);
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_bandwidth();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return Q_ONE;
			4: return $urandom;
			default: return $urandom_range(1, 32'h0010_0000);
		endcase
	endfunction

	function automatic void add_row(input dke_pkg::kind_t kind, input logic [31:0] bw,
			input logic [31:0] dst, input logic [31:0] inten, input logic [31:0] wt,
			input bit typed = 0, input logic [31:0] c = 0, input logic s = 0);
		stim_row_t r;
		r = '{kind, bw, dst, inten, wt, typed, c, s};
		directed.push_back(r);
	endfunction

	initial begin
		density_word_t typed_res;
		int gap_cap;
		arst_n    = 1'b0;
		start     = 1'b0;
		distance  = '0;
		intensity = '0;
		weight    = '0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		cur_kind  = dke_pkg::KIND_QUARTIC;
		cur_bw    = Q_ONE;
		mismatches = 0;

		// directed words: register extremes and the named corner cases
		add_row(dke_pkg::KIND_QUARTIC, Q_ONE, 32'd0, Q_ONE, Q_ONE);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, 32'd0, Q_ONE, Q_ONE, 1, Q_ONE, 0);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, Q_ONE, Q_ONE, 32'hFFFF_0000, 1,
			32'hFFFF_0000, 0);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, 32'h0001_0001, Q_ONE, Q_ONE, 1, 32'd0, 0);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, 32'd0, 32'h8000_0000, 32'h8000_0000, 1,
			32'h7FFF_FFFF, 1);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1,
			32'h8000_0000, 1);
		add_row(dke_pkg::KIND_UNIFORM, Q_ONE, 32'd0, 32'd0, 32'h8000_0000, 1, 32'd0, 0);
		add_row(KIND_SPARE_LO, Q_ONE, 32'd0, Q_ONE, Q_ONE, 1, 32'd0, 0);
		add_row(KIND_SPARE_HI, Q_ONE, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'd0, 0);
		add_row(dke_pkg::KIND_TRIANGULAR, Q_ONE, 32'd0, Q_ONE, Q_ONE, 1, Q_ONE, 0);
		add_row(dke_pkg::KIND_TRIANGULAR, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1, 32'd0, 0);
		add_row(dke_pkg::KIND_TRIANGULAR, 32'd0, 32'd0, 32'h0003_0000, 32'hFFFE_0000);
		add_row(dke_pkg::KIND_NEG_EXP, Q_ONE, 32'd0, Q_ONE, Q_ONE, 1, Q_ONE, 0);
		add_row(dke_pkg::KIND_NEG_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);
		add_row(dke_pkg::KIND_NEG_EXP, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0100_0000,
			32'h8000_0000);
		add_row(dke_pkg::KIND_QUARTIC, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000);
		add_row(dke_pkg::KIND_QUARTIC, 32'd1, 32'd1, Q_ONE, Q_ONE);
		add_row(dke_pkg::KIND_QUARTIC, 32'd0, 32'd0, 32'h0000_0001, 32'h0000_0001);
		add_row(dke_pkg::KIND_NORMAL, Q_ONE, 32'd0, Q_ONE, Q_ONE);
		add_row(dke_pkg::KIND_NORMAL, Q_ONE, 32'h0008_0000, Q_ONE, Q_ONE, 1, 32'd0, 0);
		add_row(dke_pkg::KIND_NORMAL, Q_ONE, 32'h0007_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(dke_pkg::KIND_NORMAL, 32'd0, 32'd0, 32'h0001_8000, 32'hFFFF_8000);
		add_row(dke_pkg::KIND_NORMAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[n]) begin
			if (directed[n].kind != cur_kind || directed[n].bw != cur_bw) begin
				settle();
				write_reg(dke_pkg::REG_KERNEL_KIND, {29'd0, directed[n].kind});
				write_reg(dke_pkg::REG_BANDWIDTH, directed[n].bw);
			end
			typed_res.contribution = directed[n].contribution;
			typed_res.saturated    = directed[n].saturated;
			send_word(directed[n].dst, directed[n].inten, directed[n].wt,
				$urandom_range(0, 3), directed[n].typed, typed_res);
		end

		// random phases: a fresh setting each, some phases back to back
		for (int ph = 0; ph < 14; ph++) begin
			settle();
			if ($urandom_range(0, 7) == 0) write_reg(dke_pkg::REG_KERNEL_KIND, $urandom);
			else write_reg(dke_pkg::REG_KERNEL_KIND,
				$urandom_range(dke_pkg::KIND_QUARTIC, dke_pkg::KIND_NEG_EXP));
			write_reg(dke_pkg::REG_BANDWIDTH, pick_bandwidth());
			gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 12;
			repeat (130) begin
				send_word(pick_distance(cur_bw), pick_value(), pick_value(),
					$urandom_range(0, gap_cap), 0, typed_res);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
